// ===== design/mpct_pkg.sv =====
// Shared types and constants for the mouse packet cursor tracker.
// No dependencies; imported by mpct_ctrl, mpct_dp and mouse_packet_cursor_tracker.
package mpct_pkg;

   // request codes
   localparam logic [1:0] REQ_CTRL_BYTE  = 2'd0;
   localparam logic [1:0] REQ_USB_MOTION = 2'd1;
   localparam logic [1:0] REQ_POLL       = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;

   localparam int          QUEUE_DEPTH_DEF = 32;
   localparam logic [14:0] RESET_WIDTH     = 15'd800;
   localparam logic [14:0] RESET_HEIGHT    = 15'd600;
   localparam logic [14:0] RESET_CURSOR_X  = RESET_WIDTH / 15'd2;
   localparam logic [14:0] RESET_CURSOR_Y  = RESET_HEIGHT / 15'd2;

   // ps/2 flag byte bits
   localparam int FLAG_SYNC_BIT = 3;
   localparam int FLAG_XSIGN    = 4;
   localparam int FLAG_YSIGN    = 5;
   localparam int FLAG_XOVF     = 6;
   localparam int FLAG_YOVF     = 7;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               aux_flag;
      logic [7:0]         data_byte;
      logic signed [15:0] usb_dx;
      logic signed [15:0] usb_dy;
      logic [7:0]         usb_buttons;
   } req_item_type;

   typedef struct packed {
      logic               ev_valid;
      logic signed [15:0] ev_dx;
      logic signed [15:0] ev_dy;
      logic [14:0]        ev_x;
      logic [14:0]        ev_y;
      logic [7:0]         ev_buttons;
      logic [7:0]         ev_pressed;
      logic [7:0]         ev_released;
      logic               ev_source;
      logic [14:0]        cursor_now_x;
      logic [14:0]        cursor_now_y;
      logic [31:0]        error_total;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } mpct_state_type;

   typedef struct packed {
      logic capture;    // latch request and read the ring at tail
      logic exec;       // update state and load the result register
      logic cfg_write;  // write a bound register and clamp the cursor
   } dp_cmd_type;

   // clamp a signed position into 0..bound-1
   function automatic logic [14:0] clamp_axis(input logic signed [17:0] v,
                                              input logic [14:0] bound);
      logic [14:0] res;
      if (v < 18'sd0) begin
         res = 15'd0;
      end else if (v >= $signed({3'b000, bound})) begin
         res = bound - 15'd1;
      end else begin
         res = v[14:0];
      end
      return res;
   endfunction

endpackage

// ===== design/mpct_ctrl.sv =====
// Controller state machine for the mouse packet cursor tracker.
// Depends on mpct_pkg; drives handshakes and datapath commands.
module mpct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output mpct_pkg::dp_cmd_type cmd
);
   import mpct_pkg::*;

   mpct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // config transfers win over requests when both arrive while idle
   always_comb begin
      req_ready     = 1'b0;
      csr_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready     = 1'b1;
            req_ready     = !csr_valid;
            cmd.cfg_write = csr_valid;
            cmd.capture   = req_valid && !csr_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== design/mpct_dp.sv =====
// Datapath for the mouse packet cursor tracker: packet assembly, cursor,
// buttons, error count and event ring. Depends on mpct_pkg.
module mpct_dp #(
   parameter int QUEUE_DEPTH = mpct_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mpct_pkg::dp_cmd_type   cmd,
   input  mpct_pkg::req_item_type req_data,
   input  logic [1:0]             csr_index,
   input  logic [14:0]            csr_data,
   output mpct_pkg::rsp_item_type rsp_data
);
   import mpct_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   localparam logic [1:0] POS_FLAG = 2'd0;
   localparam logic [1:0] POS_X    = 2'd1;
   localparam logic [1:0] POS_Y    = 2'd2;

   typedef struct packed {
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [14:0]        x;
      logic [14:0]        y;
      logic [7:0]         buttons;
      logic [7:0]         pressed;
      logic [7:0]         released;
      logic               source;
   } slot_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_LAST) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   req_item_type     req_ff;
   logic [14:0]      width_ff, width_in;
   logic [14:0]      height_ff, height_in;
   logic [14:0]      cur_x_ff, cur_x_in;
   logic [14:0]      cur_y_ff, cur_y_in;
   logic [7:0]       btn_ff, btn_in;
   logic [1:0]       pos_ff, pos_in;
   logic [7:0]       flag_ff, flag_in;
   logic [7:0]       xbyte_ff, xbyte_in;
   logic [31:0]      err_ff, err_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   slot_type         rd_ff;
   rsp_item_type     rsp_ff, rsp_in;

   slot_type mem [QUEUE_DEPTH];

   logic               motion;
   logic signed [15:0] mdx, mdy;
   logic [7:0]         mbtn;
   logic               msrc;
   logic               err_inc;
   logic               full;
   logic               push;
   logic [14:0]        new_x, new_y;
   logic signed [8:0]  ps2_dy;
   logic [14:0]        w_new, h_new;
   slot_type           wr_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         cur_x_ff  <= RESET_CURSOR_X;
         cur_y_ff  <= RESET_CURSOR_Y;
         btn_ff    <= '0;
         pos_ff    <= POS_FLAG;
         err_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         btn_ff    <= btn_in;
         pos_ff    <= pos_in;
         err_ff    <= err_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff  <= flag_in;
      xbyte_ff <= xbyte_in;
      if (cmd.capture) req_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   // event ring: one write port at head, registered read at tail
   always_ff @(posedge clock) begin
      if (push) mem[head_ff] <= wr_slot;
      if (cmd.capture) rd_ff <= mem[tail_ff];
   end

   // decode of the latched request into one motion
   always_comb begin
      motion   = 1'b0;
      mdx      = '0;
      mdy      = '0;
      mbtn     = btn_ff;
      msrc     = 1'b0;
      err_inc  = 1'b0;
      pos_in   = pos_ff;
      flag_in  = flag_ff;
      xbyte_in = xbyte_ff;
      ps2_dy   = $signed({flag_ff[FLAG_YSIGN], req_ff.data_byte});
      if (cmd.exec) begin
         unique case (req_ff.req_type)
            REQ_CTRL_BYTE: begin
               if (req_ff.aux_flag) begin
                  unique case (pos_ff)
                     POS_FLAG: begin
                        if (!req_ff.data_byte[FLAG_SYNC_BIT]) begin
                           err_inc = 1'b1;
                        end else begin
                           flag_in = req_ff.data_byte;
                           pos_in  = POS_X;
                        end
                     end
                     POS_X: begin
                        xbyte_in = req_ff.data_byte;
                        pos_in   = POS_Y;
                     end
                     default: begin
                        pos_in = POS_FLAG;
                        if (flag_ff[FLAG_XOVF] || flag_ff[FLAG_YOVF]) begin
                           err_inc = 1'b1;
                        end else begin
                           motion = 1'b1;
                           mdx    = {{8{flag_ff[FLAG_XSIGN]}}, xbyte_ff};
                           mdy    = -{{7{ps2_dy[8]}}, ps2_dy};
                           mbtn   = {5'b00000, flag_ff[2:0]};
                        end
                     end
                  endcase
               end
            end
            REQ_USB_MOTION: begin
               motion = 1'b1;
               mdx    = req_ff.usb_dx;
               mdy    = req_ff.usb_dy;
               mbtn   = req_ff.usb_buttons;
               msrc   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign full = (next_ptr(head_ff) == tail_ff);
   assign push = motion && !full;

   assign new_x = clamp_axis($signed({3'b000, cur_x_ff}) + $signed({{2{mdx[15]}}, mdx}),
                             width_ff);
   assign new_y = clamp_axis($signed({3'b000, cur_y_ff}) + $signed({{2{mdy[15]}}, mdy}),
                             height_ff);

   always_comb begin
      wr_slot.dx       = mdx;
      wr_slot.dy       = mdy;
      wr_slot.x        = new_x;
      wr_slot.y        = new_y;
      wr_slot.buttons  = mbtn;
      wr_slot.pressed  = mbtn & ~btn_ff;
      wr_slot.released = btn_ff & ~mbtn;
      wr_slot.source   = msrc;
   end

   // zero writes leave a bound as it was, but the cursor is still clamped
   assign w_new = (csr_index == CSR_SCREEN_WIDTH && csr_data != 15'd0) ? csr_data : width_ff;
   assign h_new = (csr_index == CSR_SCREEN_HEIGHT && csr_data != 15'd0) ? csr_data : height_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      btn_in    = btn_ff;
      err_in    = err_ff + 32'(err_inc || (push == 1'b0 && motion && !msrc));
      head_in   = push ? next_ptr(head_ff) : head_ff;
      tail_in   = tail_ff;
      rsp_in    = '0;
      if (cmd.cfg_write && (csr_index == CSR_SCREEN_WIDTH ||
                            csr_index == CSR_SCREEN_HEIGHT)) begin
         width_in  = w_new;
         height_in = h_new;
         cur_x_in  = clamp_axis($signed({3'b000, cur_x_ff}), w_new);
         cur_y_in  = clamp_axis($signed({3'b000, cur_y_ff}), h_new);
      end
      if (motion) begin
         cur_x_in = new_x;
         cur_y_in = new_y;
         btn_in   = mbtn;
      end
      if (cmd.exec && req_ff.req_type == REQ_POLL && tail_ff != head_ff) begin
         tail_in            = next_ptr(tail_ff);
         rsp_in.ev_valid    = 1'b1;
         rsp_in.ev_dx       = rd_ff.dx;
         rsp_in.ev_dy       = rd_ff.dy;
         rsp_in.ev_x        = rd_ff.x;
         rsp_in.ev_y        = rd_ff.y;
         rsp_in.ev_buttons  = rd_ff.buttons;
         rsp_in.ev_pressed  = rd_ff.pressed;
         rsp_in.ev_released = rd_ff.released;
         rsp_in.ev_source   = rd_ff.source;
      end
      rsp_in.cursor_now_x = cur_x_in;
      rsp_in.cursor_now_y = cur_y_in;
      rsp_in.error_total  = err_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/mouse_packet_cursor_tracker.sv =====
// channel | valid     | ready     | payload
// --------+-----------+-----------+------------------------------------
// request | req_valid | req_ready | req_data (mpct_pkg::req_item_type)
// result  | rsp_valid | rsp_ready | rsp_data (mpct_pkg::rsp_item_type)
// config  | csr_valid | csr_ready | csr_index, csr_data (bound value)
//
// For each item, the cycle of its transfer latches it and reads the event ring, the
// next (ST_EXEC) updates state and loads the result, and ST_RESP then shows the
// result on rsp_data until rsp_ready takes it; the controller holds one item at a time.
// Synchronous active-high reset; the ring memory needs no clearing pass.
// A stalled result holds the block until it is taken; config is taken only when idle.
module mouse_packet_cursor_tracker #(
   parameter int QUEUE_DEPTH = mpct_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mpct_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mpct_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [14:0]            csr_data
);
   import mpct_pkg::*;

   dp_cmd_type cmd;

   mpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   mpct_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid && !csr_ready))
      else $error("request transfer not followed by a busy cycle");

   a_result_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!req_ready && !csr_ready))
      else $error("input taken while a result is pending");

   a_empty_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ev_valid) |->
      (rsp_data.ev_dx == 16'sd0 && rsp_data.ev_buttons == 8'd0 &&
       rsp_data.ev_source == 1'b0))
      else $error("event fields set without an event");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cursor_now_x != 15'h7FFF && rsp_data.cursor_now_y != 15'h7FFF))
      else $error("cursor outside any legal bound");
`endif

endmodule
